[design/tcpq_pkg.sv]
// Package for the two-class priority queue: sizes, operation codes and cell link types.
`timescale 1ns / 1ps

package tcpq_pkg;

    // Storage sizes
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;

    // Counter width able to hold QUEUE_DEPTH itself
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths at the ports
    localparam int PERSON_ID_W = 16;
    localparam int COUNT_W     = 5;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Operation codes carried in tuser
    typedef enum logic [KIND_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_SERVE_GEN  = 2'd1,
        OP_SERVE_PREF = 2'd2,
        OP_WITHDRAW   = 2'd3
    } tcpq_kind_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic               en;        // a transfer is taken this cycle
        tcpq_kind_t         op;
        logic [ID_BITS-1:0] key;       // id to insert or withdraw
        logic               ins_pref;  // class of the inserted entry
        logic               ins_ok;    // insert passes duplicate and full checks
        logic               pref_any;  // at least one preferred entry queued
    } tcpq_cmd_t;

    // Signals rippled from one cell to the next, head to tail
    typedef struct packed {
        logic               valid_prev;  // previous cell holds an entry
        logic               head_pick;   // remove this cell (head serve)
        logic               pref_seen;   // a preferred entry sits ahead
        logic               removing;    // removal point is at or ahead
        logic               found;       // key matched ahead
        logic [ID_BITS-1:0] taken_id;    // id of the removed entry
        logic               taken_pref;  // class of the removed entry
    } tcpq_link_t;

endpackage

[design/tcpq_cell.sv]
// One queue slot: holds an id and class flag, compares, and shifts toward the head.
`timescale 1ns / 1ps

module tcpq_cell (
    input  logic                        aclk,
    input  tcpq_pkg::tcpq_cmd_t         cmd,
    input  logic                        valid,     // slot below occupancy
    input  tcpq_pkg::tcpq_link_t        link_in,
    input  logic [tcpq_pkg::ID_BITS-1:0] nb_id,    // tail-side neighbor
    input  logic                        nb_pref,
    output logic [tcpq_pkg::ID_BITS-1:0] id_out,
    output logic                        pref_out,
    output tcpq_pkg::tcpq_link_t        link_out
);

    logic [tcpq_pkg::ID_BITS-1:0] id_reg;
    logic                         pref_reg;
    logic                         match;
    logic                         hit_here;
    logic                         shift;
    logic                         first_free;

    // Compare and pick the removal point
    always_comb begin
        match      = valid && (id_reg == cmd.key);
        hit_here   = link_in.head_pick
                   || ((cmd.op == tcpq_pkg::OP_WITHDRAW) && match)
                   || ((cmd.op == tcpq_pkg::OP_SERVE_PREF) && cmd.pref_any
                       && valid && pref_reg && !link_in.pref_seen);
        shift      = link_in.removing || hit_here;
        first_free = !valid && link_in.valid_prev;
    end

    // Link toward the tail
    always_comb begin
        link_out.valid_prev = valid;
        link_out.head_pick  = 1'b0;
        link_out.pref_seen  = link_in.pref_seen || (valid && pref_reg);
        link_out.removing   = shift;
        link_out.found      = link_in.found || match;
        link_out.taken_id   = hit_here ? id_reg : link_in.taken_id;
        link_out.taken_pref = hit_here ? pref_reg : link_in.taken_pref;
    end

    // Slot contents: close the gap on removal, load on append
    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            if (shift) begin
                id_reg   <= nb_id;
                pref_reg <= nb_pref;
            end else if ((cmd.op == tcpq_pkg::OP_INSERT) && cmd.ins_ok && first_free) begin
                id_reg   <= cmd.key;
                pref_reg <= cmd.ins_pref;
            end
        end
    end

    assign id_out   = id_reg;
    assign pref_out = pref_reg;

endmodule

[design/two_class_priority_queue.sv]
// Top level of the two-class priority queue: cell chain, counters and result register.
//
// Usage:
//   s_axis carries one operation per transfer: tuser holds the kind (insert,
//   serve general, serve preferred, withdraw), tdata holds the id and the
//   preferred flag. m_axis returns exactly one result per operation: success,
//   served id, and the total and preferred counts after the operation.
//   The result is valid in the cycle after the input transfer. Throughput
//   is one operation per cycle while results are taken; every slot compares and
//   shifts in that cycle, and the cycle time is set by the ripple of the
//   removal and match flags through the row of QUEUE_DEPTH cells.
//   Results sit in an output register; a new input is taken while the held
//   result is being taken in the same cycle. When the receiver stalls,
//   s_axis_tready drops until the held result is taken.
//   Reset empties the queue (counts to zero) and clears m_axis_tvalid; slot
//   contents are not cleared, only slots below the occupancy are ever read.
`timescale 1ns / 1ps

module two_class_priority_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] person_id, [16] is_preferred, [23:17] zero
    input  logic [tcpq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] kind
    input  logic [tcpq_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] success, [16:1] served_id, [21:17] total_count,
    // [26:22] preferred_count, [31:27] zero
    output logic [tcpq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int D  = tcpq_pkg::QUEUE_DEPTH;
    localparam int CW = tcpq_pkg::CNT_W;

    logic                         accept;
    tcpq_pkg::tcpq_kind_t         op;
    tcpq_pkg::tcpq_cmd_t          cmd;
    tcpq_pkg::tcpq_link_t         link [D+1];
    logic [tcpq_pkg::ID_BITS-1:0] cell_id [D];
    logic                         cell_pref [D];
    logic [D-1:0]                 cell_valid;

    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    logic          full;
    logic          empty;
    logic          ok;
    logic [tcpq_pkg::PERSON_ID_W-1:0] served;

    logic                             m_valid_reg;
    logic                             res_ok_reg;
    logic [tcpq_pkg::PERSON_ID_W-1:0] res_served_reg;
    logic [tcpq_pkg::COUNT_W-1:0]     res_total_reg;
    logic [tcpq_pkg::COUNT_W-1:0]     res_pref_reg;

    // Handshake
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = tcpq_pkg::tcpq_kind_t'(s_axis_tuser);
    assign full          = (occ_reg == CW'(D));
    assign empty         = (occ_reg == '0);

    // Command to all cells
    always_comb begin
        cmd.en       = accept;
        cmd.op       = op;
        cmd.key      = tcpq_pkg::ID_BITS'(s_axis_tdata[tcpq_pkg::PERSON_ID_W-1:0]);
        cmd.ins_pref = s_axis_tdata[tcpq_pkg::PERSON_ID_W];
        cmd.ins_ok   = !link[D].found && !full;
        cmd.pref_any = (pcnt_reg != '0);
    end

    // Entry of the chain at the head
    always_comb begin
        link[0].valid_prev = 1'b1;
        link[0].head_pick  = (op == tcpq_pkg::OP_SERVE_GEN)
                          || ((op == tcpq_pkg::OP_SERVE_PREF) && (pcnt_reg == '0));
        link[0].pref_seen  = 1'b0;
        link[0].removing   = 1'b0;
        link[0].found      = 1'b0;
        link[0].taken_id   = '0;
        link[0].taken_pref = 1'b0;
    end

    // Row of cells
    for (genvar i = 0; i < D; i++) begin : g_cell
        logic [tcpq_pkg::ID_BITS-1:0] nb_id;
        logic                         nb_pref;

        assign cell_valid[i] = (CW'(i) < occ_reg);

        if (i == D - 1) begin : g_tail
            assign nb_id   = '0;
            assign nb_pref = 1'b0;
        end else begin : g_mid
            assign nb_id   = cell_id[i+1];
            assign nb_pref = cell_pref[i+1];
        end

        tcpq_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .valid    (cell_valid[i]),
            .link_in  (link[i]),
            .nb_id    (nb_id),
            .nb_pref  (nb_pref),
            .id_out   (cell_id[i]),
            .pref_out (cell_pref[i]),
            .link_out (link[i+1])
        );
    end

    // Outcome and new counts
    always_comb begin
        ok        = 1'b0;
        served    = '0;
        occ_next  = occ_reg;
        pcnt_next = pcnt_reg;
        case (op)
            tcpq_pkg::OP_INSERT: begin
                ok = cmd.ins_ok;
                if (ok) begin
                    occ_next  = occ_reg + CW'(1);
                    pcnt_next = pcnt_reg + CW'(cmd.ins_pref);
                end
            end
            tcpq_pkg::OP_SERVE_GEN, tcpq_pkg::OP_SERVE_PREF: begin
                ok = !empty;
                if (ok) begin
                    served    = tcpq_pkg::PERSON_ID_W'(link[D].taken_id);
                    occ_next  = occ_reg - CW'(1);
                    pcnt_next = pcnt_reg - CW'(link[D].taken_pref);
                end
            end
            tcpq_pkg::OP_WITHDRAW: begin
                ok = link[D].found;
                if (ok) begin
                    occ_next  = occ_reg - CW'(1);
                    pcnt_next = pcnt_reg - CW'(link[D].taken_pref);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // Counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg  <= '0;
            pcnt_reg <= '0;
        end else if (accept) begin
            occ_reg  <= occ_next;
            pcnt_reg <= pcnt_next;
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_ok_reg     <= ok;
            res_served_reg <= served;
            res_total_reg  <= tcpq_pkg::COUNT_W'(occ_next);
            res_pref_reg   <= tcpq_pkg::COUNT_W'(pcnt_next);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = tcpq_pkg::M_TDATA_W'({res_pref_reg, res_total_reg,
                                                 res_served_reg, res_ok_reg});

    // Checks
    a_pref_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= occ_reg)
        else $error("preferred count exceeds total count");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(D))
        else $error("occupancy beyond queue depth");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted operation produced no result");

    a_fail_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_ok_reg) |-> (res_served_reg == '0))
        else $error("failed operation reports a served id");

endmodule
